/* rtl/core/cau_pkg.sv */
// Shared widths, codes, types and the saturation helper of the complex arithmetic unit.
package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Product, sum, divisor, quotient, numerator and compare widths.
  localparam int PW  = 2 * WORD_BITS;
  localparam int SW  = PW + 1;
  localparam int DW  = PW;
  localparam int QW  = WORD_BITS + 1;
  localparam int NW  = SW + FRAC_BITS;
  localparam int DSW = DW + QW - 1;
  localparam int CW  = (NW > DSW) ? NW : DSW;

  typedef logic [2:0] func_t;
  localparam func_t FN_ADD = 3'd0;
  localparam func_t FN_SUB = 3'd1;
  localparam func_t FN_MUL = 3'd2;
  localparam func_t FN_DIV = 3'd3;
  localparam func_t FN_EQ  = 3'd4;
  localparam func_t FN_NE  = 3'd5;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DZ  = 2'd1,
    ST_SAT = 2'd2
  } status_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] re;
    logic [WORD_BITS-1:0] im;
    logic                 truth;
    status_t              status;
  } res_t;

  typedef struct packed {
    logic is_div;
    logic neg_re;
    logic neg_im;
    logic big_re;
    logic big_im;
  } dflag_t;

  typedef struct packed {
    logic           valid;
    res_t           res;
    dflag_t         flg;
    logic [DSW-1:0] dsh;
    logic [CW-1:0]  rem_re;
    logic [CW-1:0]  rem_im;
    logic [QW-1:0]  quo_re;
    logic [QW-1:0]  quo_im;
  } dstage_t;

  typedef struct packed {
    logic                 sat;
    logic [WORD_BITS-1:0] word;
  } wsat_t;

  // Clamp a sign-magnitude value into a signed word.
  function automatic wsat_t sat_mag(input logic neg, input logic [CW-1:0] mag);
    logic [CW-1:0] lim;
    logic [CW-1:0] m;
    logic [CW-1:0] t;
    wsat_t         r;
    lim = CW'(1) << (WORD_BITS - 1);
    if (neg) begin
      r.sat = (mag > lim);
      m     = r.sat ? lim : mag;
      t     = '0 - m;
    end else begin
      r.sat = (mag > (lim - CW'(1)));
      m     = r.sat ? (lim - CW'(1)) : mag;
      t     = m;
    end
    r.word = t[WORD_BITS-1:0];
    return r;
  endfunction

endpackage

/* rtl/core/cau_div_step.sv */
// One restoring-division stage: resolves one quotient bit for both parts.
module cau_div_step
  import cau_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  dstage_t d_in,
  output dstage_t d_out
);

  dstage_t       st_nxt;
  dstage_t       pay_r;
  logic          valid_r;
  logic [CW-1:0] dsh_ext;
  logic          ge_re;
  logic          ge_im;

  always_comb begin
    dsh_ext       = CW'(d_in.dsh);
    ge_re         = (d_in.rem_re >= dsh_ext);
    ge_im         = (d_in.rem_im >= dsh_ext);
    st_nxt        = d_in;
    st_nxt.rem_re = ge_re ? (d_in.rem_re - dsh_ext) : d_in.rem_re;
    st_nxt.rem_im = ge_im ? (d_in.rem_im - dsh_ext) : d_in.rem_im;
    st_nxt.quo_re = {d_in.quo_re[QW-2:0], ge_re};
    st_nxt.quo_im = {d_in.quo_im[QW-2:0], ge_im};
    st_nxt.dsh    = d_in.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= d_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay_r <= st_nxt;
    end
  end

  always_comb begin
    d_out       = pay_r;
    d_out.valid = valid_r;
  end

endmodule

/* rtl/core/complex_arith_unit.sv */
// Top level of the pipelined complex arithmetic unit.
//
// Usage: each input request carries an operation code and two complex operands
// in signed Q16.16. The operations are add, subtract, multiply, divide, equal and
// not equal. Every request yields exactly one result request with the real and
// imaginary parts, a truth flag for the comparisons and a status code.
// Both channels use valid and stall; a request moves on an edge where valid is
// high and stall is low.
// Every operation takes the same path from acceptance to out_valid: four
// front stages (products, sums, magnitudes, numerator setup), 33 divider stages
// that each resolve one quotient bit, and the output register. One request can be
// accepted in every cycle while in_stall is low.
// Reset clears all valid bits; the unit keeps no other state.
// When the receiver stalls a valid result, the whole pipeline freezes and
// in_stall is raised, so no request is dropped or repeated.
module complex_arith_unit
  import cau_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_func,
  input  logic signed [WORD_BITS-1:0] in_x_re,
  input  logic signed [WORD_BITS-1:0] in_x_im,
  input  logic signed [WORD_BITS-1:0] in_y_re,
  input  logic signed [WORD_BITS-1:0] in_y_im,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] out_res_re,
  output logic signed [WORD_BITS-1:0] out_res_im,
  output logic                        out_truth,
  output logic [1:0]                  out_status
);

  // The pipeline advances whenever the output register is free or being drained.
  logic en;
  logic out_valid_r;
  res_t out_res_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Stage 1: the six products, the add/subtract sums and the compares.
  logic                      s1_valid_r;
  func_t                     s1_func_r;
  logic signed [PW-1:0]      s1_p_rr_r, s1_p_ii_r, s1_p_ri_r, s1_p_ir_r;
  logic signed [PW-1:0]      s1_sq_r_r, s1_sq_i_r;
  logic signed [WORD_BITS:0] s1_as_re_r, s1_as_im_r;
  logic                      s1_eq_r;
  logic                      s1_dz_r;

  logic signed [PW-1:0]      s1_p_rr_nxt, s1_p_ii_nxt, s1_p_ri_nxt, s1_p_ir_nxt;
  logic signed [PW-1:0]      s1_sq_r_nxt, s1_sq_i_nxt;
  logic signed [WORD_BITS:0] s1_as_re_nxt, s1_as_im_nxt;

  assign s1_p_rr_nxt = in_x_re * in_y_re;
  assign s1_p_ii_nxt = in_x_im * in_y_im;
  assign s1_p_ri_nxt = in_x_re * in_y_im;
  assign s1_p_ir_nxt = in_x_im * in_y_re;
  assign s1_sq_r_nxt = in_y_re * in_y_re;
  assign s1_sq_i_nxt = in_y_im * in_y_im;

  always_comb begin
    if (in_func == FN_SUB) begin
      s1_as_re_nxt = in_x_re - in_y_re;
      s1_as_im_nxt = in_x_im - in_y_im;
    end else begin
      s1_as_re_nxt = in_x_re + in_y_re;
      s1_as_im_nxt = in_x_im + in_y_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_func_r  <= in_func;
      s1_p_rr_r  <= s1_p_rr_nxt;
      s1_p_ii_r  <= s1_p_ii_nxt;
      s1_p_ri_r  <= s1_p_ri_nxt;
      s1_p_ir_r  <= s1_p_ir_nxt;
      s1_sq_r_r  <= s1_sq_r_nxt;
      s1_sq_i_r  <= s1_sq_i_nxt;
      s1_as_re_r <= s1_as_re_nxt;
      s1_as_im_r <= s1_as_im_nxt;
      s1_eq_r    <= (in_x_re == in_y_re) && (in_x_im == in_y_im);
      s1_dz_r    <= (in_y_re == '0) && (in_y_im == '0);
    end
  end

  // Stage 2: cross sums for multiply or divide, the divisor, and the final
  // result of every operation that needs no product.
  logic                 s2_valid_r;
  logic signed [SW-1:0] s2_sum_re_r, s2_sum_im_r;
  logic [DW-1:0]        s2_d_r;
  res_t                 s2_res_r;
  logic                 s2_mul_r;
  logic                 s2_div_r;

  logic signed [SW-1:0] s2_sum_re_nxt, s2_sum_im_nxt;
  logic [DW-1:0]        s2_d_nxt;
  res_t                 s2_res_nxt;
  logic [WORD_BITS:0]   am_re, am_im;
  wsat_t                as_re_w, as_im_w;

  always_comb begin
    if (s1_func_r == FN_DIV) begin
      s2_sum_re_nxt = s1_p_rr_r + s1_p_ii_r;
      s2_sum_im_nxt = s1_p_ir_r - s1_p_ri_r;
    end else begin
      s2_sum_re_nxt = s1_p_rr_r - s1_p_ii_r;
      s2_sum_im_nxt = s1_p_ri_r + s1_p_ir_r;
    end
    s2_d_nxt = DW'($unsigned(s1_sq_r_r)) + DW'($unsigned(s1_sq_i_r));

    am_re   = s1_as_re_r[WORD_BITS] ? $unsigned(-s1_as_re_r) : $unsigned(s1_as_re_r);
    am_im   = s1_as_im_r[WORD_BITS] ? $unsigned(-s1_as_im_r) : $unsigned(s1_as_im_r);
    as_re_w = sat_mag(s1_as_re_r[WORD_BITS], CW'(am_re));
    as_im_w = sat_mag(s1_as_im_r[WORD_BITS], CW'(am_im));

    s2_res_nxt = '{re: '0, im: '0, truth: 1'b0, status: ST_OK};
    case (s1_func_r)
      FN_ADD, FN_SUB: begin
        s2_res_nxt.re     = as_re_w.word;
        s2_res_nxt.im     = as_im_w.word;
        s2_res_nxt.status = (as_re_w.sat || as_im_w.sat) ? ST_SAT : ST_OK;
      end
      FN_DIV: begin
        s2_res_nxt.status = s1_dz_r ? ST_DZ : ST_OK;
      end
      FN_EQ: begin
        s2_res_nxt.truth = s1_eq_r;
      end
      FN_NE: begin
        s2_res_nxt.truth = !s1_eq_r;
      end
      default: begin
        s2_res_nxt.truth = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sum_re_r <= s2_sum_re_nxt;
      s2_sum_im_r <= s2_sum_im_nxt;
      s2_d_r      <= s2_d_nxt;
      s2_res_r    <= s2_res_nxt;
      s2_mul_r    <= (s1_func_r == FN_MUL);
      s2_div_r    <= (s1_func_r == FN_DIV) && !s1_dz_r;
    end
  end

  // Stage 3: sign and magnitude of both sums.
  logic          s3_valid_r;
  logic          s3_neg_re_r, s3_neg_im_r;
  logic [SW-1:0] s3_mag_re_r, s3_mag_im_r;
  logic [DW-1:0] s3_d_r;
  res_t          s3_res_r;
  logic          s3_mul_r;
  logic          s3_div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_neg_re_r <= s2_sum_re_r[SW-1];
      s3_neg_im_r <= s2_sum_im_r[SW-1];
      s3_mag_re_r <= s2_sum_re_r[SW-1] ? $unsigned(-s2_sum_re_r) : $unsigned(s2_sum_re_r);
      s3_mag_im_r <= s2_sum_im_r[SW-1] ? $unsigned(-s2_sum_im_r) : $unsigned(s2_sum_im_r);
      s3_d_r      <= s2_d_r;
      s3_res_r    <= s2_res_r;
      s3_mul_r    <= s2_mul_r;
      s3_div_r    <= s2_div_r;
    end
  end

  // Stage 4: the product result is scaled and clamped; the divider is loaded.
  // A quotient of 2^33 or more is flagged here, so the chain needs only 33 bits.
  logic          s4_valid_r;
  dstage_t       s4_pay_r;
  dstage_t       s4_nxt;
  logic [CW-1:0] num_re, num_im, d_ext;
  wsat_t         mul_re_w, mul_im_w;

  always_comb begin
    num_re   = CW'(s3_mag_re_r) << FRAC_BITS;
    num_im   = CW'(s3_mag_im_r) << FRAC_BITS;
    d_ext    = CW'(s3_d_r);
    mul_re_w = sat_mag(s3_neg_re_r, CW'(s3_mag_re_r >> FRAC_BITS));
    mul_im_w = sat_mag(s3_neg_im_r, CW'(s3_mag_im_r >> FRAC_BITS));

    s4_nxt            = '0;
    s4_nxt.res        = s3_res_r;
    if (s3_mul_r) begin
      s4_nxt.res.re     = mul_re_w.word;
      s4_nxt.res.im     = mul_im_w.word;
      s4_nxt.res.status = (mul_re_w.sat || mul_im_w.sat) ? ST_SAT : ST_OK;
    end
    s4_nxt.flg.is_div = s3_div_r;
    s4_nxt.flg.neg_re = s3_neg_re_r;
    s4_nxt.flg.neg_im = s3_neg_im_r;
    s4_nxt.flg.big_re = ((num_re >> QW) >= d_ext);
    s4_nxt.flg.big_im = ((num_im >> QW) >= d_ext);
    s4_nxt.dsh        = DSW'(s3_d_r) << (QW - 1);
    s4_nxt.rem_re     = num_re;
    s4_nxt.rem_im     = num_im;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_pay_r <= s4_nxt;
    end
  end

  // Divider chain: one quotient bit per stage, most significant first.
  dstage_t chain [QW+1];

  always_comb begin
    chain[0]       = s4_pay_r;
    chain[0].valid = s4_valid_r;
  end

  for (genvar gi = 0; gi < QW; gi++) begin : g_div
    cau_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (chain[gi]),
      .d_out (chain[gi+1])
    );
  end

  // Output stage: clamp the quotients and pick the final result.
  res_t  out_res_nxt;
  wsat_t q_re_w, q_im_w;

  always_comb begin
    q_re_w = sat_mag(chain[QW].flg.neg_re,
                     chain[QW].flg.big_re ? '1 : CW'(chain[QW].quo_re));
    q_im_w = sat_mag(chain[QW].flg.neg_im,
                     chain[QW].flg.big_im ? '1 : CW'(chain[QW].quo_im));
    out_res_nxt = chain[QW].res;
    if (chain[QW].flg.is_div) begin
      out_res_nxt.re     = q_re_w.word;
      out_res_nxt.im     = q_im_w.word;
      out_res_nxt.truth  = 1'b0;
      out_res_nxt.status = (q_re_w.sat || q_im_w.sat) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_res_re = out_res_r.re;
  assign out_res_im = out_res_r.im;
  assign out_truth  = out_res_r.truth;
  assign out_status = out_res_r.status;

  // A zero divisor must never leak partial quotient data.
  a_dz_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_DZ) |->
      (out_res_re == '0) && (out_res_im == '0) && !out_truth)
    else $error("divide-by-zero result carries nonzero data");

  // A true comparison never comes with arithmetic data or a status.
  a_truth_clean : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truth |->
      (out_res_re == '0) && (out_res_im == '0) && (out_status == ST_OK))
    else $error("comparison result mixed with arithmetic data");

  // An accepted request enters the first stage.
  a_take : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_valid_r)
    else $error("accepted request lost at the first stage");

  // While the pipeline is frozen, the last divider stage keeps its request.
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    chain[QW].valid && in_stall |=> chain[QW].valid)
    else $error("request dropped from the divider chain during a stall");

endmodule
